>>> rtl/core/ium_pkg.sv
// Package for the ISO 8583 message unpacker.
// Holds the shared codes, the result word type and the hex character helper.
// No dependencies.
`timescale 1ns / 1ps
package ium_pkg;

	// Input operation codes.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_BYTE = 1'b1;

	// Result section codes.
	localparam logic [2:0] SEC_TPDU   = 3'd0;
	localparam logic [2:0] SEC_HEADER = 3'd1;
	localparam logic [2:0] SEC_TYPE   = 3'd2;
	localparam logic [2:0] SEC_FIELD  = 3'd3;
	localparam logic [2:0] SEC_STATUS = 3'd4;

	// Final status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_TRUNC    = 3'd1;
	localparam logic [2:0] ST_BAD_KIND = 3'd2;
	localparam logic [2:0] ST_BAD_LEN  = 3'd3;
	localparam logic [2:0] ST_BAD_DATA = 3'd4;

	// Length kinds and codings.
	localparam logic [1:0] KIND_FIXED   = 2'd0;
	localparam logic [1:0] KIND_LL      = 2'd1;
	localparam logic [1:0] KIND_LLL     = 2'd2;
	localparam logic [1:0] KIND_INVALID = 2'd3;
	localparam logic [1:0] CODE_ASCII   = 2'd0;
	localparam logic [1:0] CODE_INVALID = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_TPDU   = 2'd0;
	localparam logic [1:0] CFG_HEADER = 2'd1;

	localparam logic [3:0] TPDU_RESET   = 4'd5;
	localparam logic [3:0] HEADER_RESET = 4'd6;
	localparam logic [9:0] TYPE_BYTES   = 10'd2;

	// Output queue sizing: one byte makes at most three words.
	localparam int FIFO_DEPTH    = 8;
	localparam int FIFO_PUSH_MAX = 3;

	typedef logic [15:0] field_def_t;

	typedef struct packed {
		logic [2:0] section;
		logic [6:0] field_number;
		logic [7:0] character;
		logic       last_of_run;
		logic [2:0] status;
	} out_word_t;

	typedef struct packed {
		logic [1:0]                     count;
		out_word_t [FIFO_PUSH_MAX-1:0] word;
	} push_t;

	typedef enum logic [9:0] {
		PH_TPDU   = 10'b0000000001,
		PH_HEADER = 10'b0000000010,
		PH_TYPE   = 10'b0000000100,
		PH_BITMAP = 10'b0000001000,
		PH_LEN    = 10'b0000010000,
		PH_DATA   = 10'b0000100000,
		PH_DONE   = 10'b0001000000,
		PH_ERROR  = 10'b0010000000,
		PH_FIND   = 10'b0100000000,
		PH_EVAL   = 10'b1000000000
	} phase_t;

	// One nibble as an uppercase hex character.
	function automatic logic [7:0] hex_char(input logic [3:0] d);
		if (d < 4'd10) begin
			return 8'h30 + {4'd0, d};
		end
		return 8'h37 + {4'd0, d};
	endfunction

endpackage

>>> rtl/core/ium_field_table.sv
// Field definition table: one synchronous memory, one write and one read port.
// Depends on ium_pkg for the definition type.
`timescale 1ns / 1ps
module ium_field_table
	import ium_pkg::*;
#(
	parameter int FIELD_COUNT = 64
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(FIELD_COUNT)-1:0] wr_addr,
	input  field_def_t                     wr_data,
	input  logic                           rd_en,
	input  logic [$clog2(FIELD_COUNT)-1:0] rd_addr,
	output field_def_t                     rd_data
);

	field_def_t mem [FIELD_COUNT];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/core/ium_out_fifo.sv
// Result queue that takes up to three words a cycle and gives one.
// Depends on ium_pkg for the word and push types.
`timescale 1ns / 1ps
module ium_out_fifo
	import ium_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  push_t     push,
	input  logic      pop,
	output out_word_t head,
	output logic      not_empty,
	output logic      near_full
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	out_word_t      store_q [FIFO_DEPTH];
	logic [PW-1:0]  wp_q;
	logic [PW-1:0]  rp_q;
	logic [CW-1:0]  count_q;

	// Word storage, written at consecutive slots.
	always_ff @(posedge clk) begin
		for (int k = 0; k < FIFO_PUSH_MAX; k++) begin
			if (k < int'(push.count)) begin
				store_q[wp_q + PW'(k)] <= push.word[k];
			end
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + PW'(push.count);
			rp_q    <= rp_q + PW'(pop);
			count_q <= count_q + CW'(push.count) - CW'(pop);
		end
	end

	assign head      = store_q[rp_q];
	assign not_empty = (count_q != '0);
	assign near_full = (count_q > CW'(FIFO_DEPTH - FIFO_PUSH_MAX));

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> ({1'b0, count_q} + (CW+1)'(push.count)) <= (CW+1)'(FIFO_DEPTH))
		else $error("result queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("result queue underflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(FIFO_DEPTH))
		else $error("result queue count out of range");

endmodule

>>> rtl/core/ium_parser.sv
// Message parser: section sequencing, bitmap, length prefixes and field scan.
// Depends on ium_pkg; reads definitions from ium_field_table in the cycle after each read.
`timescale 1ns / 1ps
module ium_parser
	import ium_pkg::*;
#(
	parameter int FIELD_COUNT     = 64,
	parameter int MAX_FIELD_CHARS = 999,
	parameter int BITMAP_BYTES    = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_fire,
	input  logic                           opcode,
	input  logic [5:0]                     def_index,
	input  field_def_t                     load_def,
	input  logic [7:0]                     data_byte,
	input  logic                           end_of_message,
	input  logic [3:0]                     tpdu_bytes,
	input  logic [3:0]                     header_bytes,
	input  field_def_t                     rd_data,
	output logic                           rd_en,
	output logic [$clog2(FIELD_COUNT)-1:0] rd_addr,
	output push_t                          push,
	output logic                           busy
);

	localparam int MAP_BITS = BITMAP_BYTES * 8;
	localparam int IW       = $clog2(MAP_BITS);
	localparam int FW       = $clog2(FIELD_COUNT + 1);
	localparam int AW       = $clog2(FIELD_COUNT);
	localparam logic [9:0] MAX_LEN = 10'(MAX_FIELD_CHARS);

	phase_t              phase_q, phase_d;
	logic [9:0]          left_q, left_d;
	logic [FW-1:0]       cur_q, cur_d;
	logic [9:0]          acc_q, acc_d;
	logic [2:0]          err_q, err_d;
	logic [MAP_BITS-1:0] map_q, map_d;
	logic                pend_q, pend_d;
	field_def_t          def_q, def_d;

	// One length digit; bad digits count as zero, the total saturates.
	function automatic logic [9:0] add_digit(input logic [9:0] acc, input logic [3:0] dg);
		logic [13:0] v;
		v = {acc, 3'b000} + {3'b000, acc, 1'b0} + {10'd0, (dg > 4'd9) ? 4'd0 : dg};
		return (v > 14'(MAX_LEN)) ? MAX_LEN : v[9:0];
	endfunction

	// Byte count of a field's data from its length and coding.
	function automatic logic [9:0] data_bytes(input logic [9:0] len, input logic [1:0] coding);
		logic [10:0] s;
		s = {1'b0, len} + 11'd1;
		return (coding == CODE_ASCII) ? len : s[10:1];
	endfunction

	function automatic out_word_t mk_word(input logic [2:0] sec, input logic [6:0] fld,
			input logic [7:0] ch);
		out_word_t w;
		w.section      = sec;
		w.field_number = fld;
		w.character    = ch;
		w.last_of_run  = 1'b0;
		w.status       = ST_OK;
		return w;
	endfunction

	// Next-state and result logic.
	always_comb begin
		phase_t                      ph;
		logic [9:0]                  lft;
		logic [1:0]                  n;
		logic                        eom;
		logic                        finish;
		logic                        found;
		logic [IW-1:0]               hit;
		int                          loi;
		logic [9:0]                  len;
		logic [9:0]                  nb;
		logic [2:0]                  sec;
		logic [3:0]                  dg;
		out_word_t [FIFO_PUSH_MAX-1:0] wd;
		out_word_t                   sw;

		phase_d = phase_q;
		left_d  = left_q;
		cur_d   = cur_q;
		acc_d   = acc_q;
		err_d   = err_q;
		map_d   = map_q;
		pend_d  = pend_q;
		def_d   = def_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		wd      = '0;
		n       = 2'd0;
		found   = 1'b0;
		hit     = '0;
		len     = '0;
		nb      = '0;
		sec     = SEC_TPDU;
		dg      = '0;
		sw      = '0;
		loi     = 1;
		eom     = in_fire && (opcode == OP_BYTE) && end_of_message;
		ph      = phase_q;
		lft     = left_q;

		// The first byte of a message picks the first non-empty section.
		if (phase_q == PH_TPDU && left_q == '0) begin
			if (tpdu_bytes != '0) begin
				lft = {6'd0, tpdu_bytes};
			end else if (header_bytes != '0) begin
				ph  = PH_HEADER;
				lft = {6'd0, header_bytes};
			end else begin
				ph  = PH_TYPE;
				lft = TYPE_BYTES;
			end
		end

		if (in_fire && opcode == OP_BYTE) begin
			unique case (ph)
				PH_TPDU, PH_HEADER, PH_TYPE: begin
					sec = (ph == PH_TPDU) ? SEC_TPDU : (ph == PH_HEADER) ? SEC_HEADER : SEC_TYPE;
					wd[0]   = mk_word(sec, 7'd0, hex_char(data_byte[7:4]));
					wd[1]   = mk_word(sec, 7'd0, hex_char(data_byte[3:0]));
					n       = 2'd2;
					phase_d = ph;
					left_d  = lft - 10'd1;
					if (lft == 10'd1) begin
						if (ph == PH_TPDU && header_bytes != '0) begin
							phase_d = PH_HEADER;
							left_d  = {6'd0, header_bytes};
						end else if (ph != PH_TYPE) begin
							phase_d = PH_TYPE;
							left_d  = TYPE_BYTES;
						end else begin
							phase_d = PH_BITMAP;
							left_d  = 10'(BITMAP_BYTES);
						end
					end
				end
				PH_BITMAP: begin
					// Bit 7 of the first bitmap byte belongs to field 1.
					for (int p = 0; p < BITMAP_BYTES; p++) begin
						if (10'(p) == 10'(BITMAP_BYTES) - lft) begin
							for (int j = 0; j < 8; j++) begin
								map_d[p*8 + j] = data_byte[7 - j];
							end
						end
					end
					left_d = lft - 10'd1;
					if (lft == 10'd1) begin
						phase_d = PH_FIND;
					end
				end
				PH_LEN: begin
					if (def_q[13:12] == CODE_ASCII) begin
						dg = (data_byte >= 8'h30 && data_byte <= 8'h39) ? data_byte[3:0] : 4'd0;
						acc_d = add_digit(acc_q, dg);
					end else begin
						acc_d = add_digit(add_digit(acc_q, data_byte[7:4]), data_byte[3:0]);
					end
					left_d = lft - 10'd1;
					if (lft == 10'd1) begin
						nb = data_bytes(acc_d, def_q[11:10]);
						if (def_q[11:10] == CODE_INVALID) begin
							phase_d = PH_ERROR;
							err_d   = ST_BAD_DATA;
							left_d  = '0;
						end else if (nb == '0) begin
							phase_d = PH_FIND;
						end else begin
							phase_d = PH_DATA;
							left_d  = nb;
						end
					end
				end
				PH_DATA: begin
					if (def_q[11:10] == CODE_ASCII) begin
						wd[0] = mk_word(SEC_FIELD, 7'(cur_q), data_byte);
						n     = 2'd1;
					end else begin
						wd[0] = mk_word(SEC_FIELD, 7'(cur_q), hex_char(data_byte[7:4]));
						wd[1] = mk_word(SEC_FIELD, 7'(cur_q), hex_char(data_byte[3:0]));
						n     = 2'd2;
					end
					left_d = lft - 10'd1;
					if (lft == 10'd1) begin
						phase_d = PH_FIND;
					end
				end
				default: begin
				end
			endcase
			if (n != 2'd0 && !eom) begin
				wd[n - 2'd1].last_of_run = 1'b1;
			end
		end else if (phase_q == PH_FIND) begin
			// Lowest present field above the current one, from field 2 on.
			loi = (cur_q == '0) ? 1 : int'(cur_q);
			for (int i = MAP_BITS - 1; i >= 0; i--) begin
				if (map_q[i] && i >= loi && i < FIELD_COUNT) begin
					found = 1'b1;
					hit   = IW'(i);
				end
			end
			if (found) begin
				rd_en   = 1'b1;
				rd_addr = AW'(hit);
				cur_d   = FW'(hit) + FW'(1);
				phase_d = PH_EVAL;
			end else begin
				phase_d = PH_DONE;
				left_d  = '0;
			end
		end else if (phase_q == PH_EVAL) begin
			// Definition of the field just found.
			def_d = rd_data;
			if (rd_data[15:14] == KIND_INVALID) begin
				phase_d = PH_ERROR;
				err_d   = ST_BAD_KIND;
				left_d  = '0;
			end else if (rd_data[15:14] == KIND_FIXED) begin
				len   = (rd_data[9:0] > MAX_LEN) ? MAX_LEN : rd_data[9:0];
				acc_d = len;
				nb    = data_bytes(len, rd_data[11:10]);
				if (rd_data[11:10] == CODE_INVALID) begin
					phase_d = PH_ERROR;
					err_d   = ST_BAD_DATA;
					left_d  = '0;
				end else if (nb == '0) begin
					phase_d = PH_FIND;
				end else begin
					phase_d = PH_DATA;
					left_d  = nb;
				end
			end else if (rd_data[13:12] == CODE_INVALID) begin
				phase_d = PH_ERROR;
				err_d   = ST_BAD_LEN;
				left_d  = '0;
			end else begin
				phase_d = PH_LEN;
				acc_d   = '0;
				if (rd_data[15:14] == KIND_LL) begin
					left_d = (rd_data[13:12] == CODE_ASCII) ? 10'd2 : 10'd1;
				end else begin
					left_d = (rd_data[13:12] == CODE_ASCII) ? 10'd3 : 10'd2;
				end
			end
		end

		// A definition load for the field in progress takes effect at once.
		if (in_fire && opcode == OP_LOAD && cur_q != '0
				&& FW'(def_index) + FW'(1) == cur_q) begin
			def_d = load_def;
		end

		// Final status once the end of the message and any field scan are done.
		if (eom && phase_d == PH_FIND) begin
			pend_d = 1'b1;
		end
		finish = (eom && phase_d != PH_FIND)
			|| (pend_q && (phase_q == PH_FIND || phase_q == PH_EVAL)
				&& phase_d != PH_FIND && phase_d != PH_EVAL);
		if (finish) begin
			sw.section     = SEC_STATUS;
			sw.last_of_run = 1'b1;
			sw.status      = (phase_d == PH_DONE) ? ST_OK : (phase_d == PH_ERROR) ? err_d : ST_TRUNC;
			wd[n]   = sw;
			n       = n + 2'd1;
			phase_d = PH_TPDU;
			left_d  = '0;
			cur_d   = '0;
			acc_d   = '0;
			err_d   = ST_OK;
			map_d   = '0;
			pend_d  = 1'b0;
		end

		push.count = n;
		push.word  = wd;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TPDU;
			left_q  <= '0;
			cur_q   <= '0;
			acc_q   <= '0;
			err_q   <= ST_OK;
			map_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			left_q  <= left_d;
			cur_q   <= cur_d;
			acc_q   <= acc_d;
			err_q   <= err_d;
			map_q   <= map_d;
			pend_q  <= pend_d;
		end
	end

	// Cached definition of the current field.
	always_ff @(posedge clk) begin
		def_q <= def_d;
	end

	assign busy = (phase_q == PH_FIND) || (phase_q == PH_EVAL);

	a_eval_after_find: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_EVAL |-> $past(phase_q) == PH_FIND)
		else $error("definition used without a table read");
	a_no_byte_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_fire)
		else $error("item taken during field scan");
	a_pend_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> busy)
		else $error("pending status outside field scan");

endmodule

>>> rtl/core/iso8583_message_unpacker_top.sv
// Output: a byte's words enter the result queue at acceptance, whose storage is registered.
// Throughput: one item per cycle unless stalled; each present field start adds a bitmap
// search, then a definition table read, which stall input; skipped empty fields the same.
// The result queue (eight words) stalls input when fewer than three slots are free.
// Reset: arst_n clears the parse state and sets tpdu_bytes to 5, header_bytes to 6;
// the definition table holds garbage until loaded.
`timescale 1ns / 1ps
module iso8583_message_unpacker_top
	import ium_pkg::*;
#(
	parameter int FIELD_COUNT     = 64,
	parameter int MAX_FIELD_CHARS = 999,
	parameter int BITMAP_BYTES    = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       opcode,
	input  logic [5:0] def_index,
	input  logic [1:0] len_kind,
	input  logic [1:0] len_coding,
	input  logic [1:0] data_coding,
	input  logic [9:0] fixed_length,
	input  logic [7:0] data_byte,
	input  logic       end_of_message,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] section,
	output logic [6:0] field_number,
	output logic [7:0] character,
	output logic       last_of_run,
	output logic [2:0] status,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data
);

	localparam int AW = $clog2(FIELD_COUNT);

	logic       in_fire;
	logic [3:0] tpdu_q;
	logic [3:0] header_q;
	field_def_t load_def;
	field_def_t rd_data;
	logic       rd_en;
	logic [AW-1:0] rd_addr;
	push_t      push;
	logic       busy;
	logic       near_full;
	out_word_t  head;

	assign in_fire  = in_valid && !in_stall;
	assign in_stall = busy || near_full;
	assign load_def = {len_kind, len_coding, data_coding, fixed_length};

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpdu_q   <= TPDU_RESET;
			header_q <= HEADER_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TPDU:   tpdu_q   <= cfg_data;
				CFG_HEADER: header_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ium_field_table #(
		.FIELD_COUNT(FIELD_COUNT)
	) u_table (
		.clk     (clk),
		.wr_en   (in_fire && opcode == OP_LOAD),
		.wr_addr (AW'(def_index)),
		.wr_data (load_def),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ium_parser #(
		.FIELD_COUNT     (FIELD_COUNT),
		.MAX_FIELD_CHARS (MAX_FIELD_CHARS),
		.BITMAP_BYTES    (BITMAP_BYTES)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_fire        (in_fire),
		.opcode         (opcode),
		.def_index      (def_index),
		.load_def       (load_def),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.tpdu_bytes     (tpdu_q),
		.header_bytes   (header_q),
		.rd_data        (rd_data),
		.rd_en          (rd_en),
		.rd_addr        (rd_addr),
		.push           (push),
		.busy           (busy)
	);

	ium_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (out_valid && !out_stall),
		.head      (head),
		.not_empty (out_valid),
		.near_full (near_full)
	);

	assign section      = head.section;
	assign field_number = head.field_number;
	assign character    = head.character;
	assign last_of_run  = head.last_of_run;
	assign status       = head.status;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the ISO 8583 message unpacker.
// Builds random field tables and messages, predicts every output word and compares.
// Depends on ium_pkg and iso8583_message_unpacker_top.
`timescale 1ns / 1ps
module tb_top;
	import ium_pkg::*;

	typedef struct {
		logic       op;
		logic [5:0] idx;
		logic [1:0] kind;
		logic [1:0] lcode;
		logic [1:0] dcode;
		logic [9:0] flen;
		logic [7:0] b;
		logic       eom;
	} msg_item_t;

	typedef enum int {
		P_TPDU, P_HDR, P_TYPE, P_BMAP, P_LEN, P_DATA, P_DONE, P_ERR
	} parse_ph_t;

	logic clk;
	logic arst_n;
	logic in_valid, in_stall;
	logic opcode;
	logic [5:0] def_index;
	logic [1:0] len_kind, len_coding, data_coding;
	logic [9:0] fixed_length;
	logic [7:0] data_byte;
	logic end_of_message;
	logic out_valid, out_stall;
	logic [2:0] section;
	logic [6:0] field_number;
	logic [7:0] character;
	logic last_of_run;
	logic [2:0] status;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [3:0] cfg_data;

	iso8583_message_unpacker_top u_top (.*);

	// Clock.
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	msg_item_t pending_q[$];
	msg_item_t cur_item;
	out_word_t want_q[$];
	int fails = 0;
	int cyc = 0;
	int quiet_cnt = 0;

	// Generator view of the table and the section sizes.
	logic [15:0] gen_tab[64];
	int gen_tpdu = 5;
	int gen_hdr = 6;

	// Predictor state.
	logic [15:0] def_tab[64];
	logic [63:0] pres_map;
	parse_ph_t ph;
	int cur_fld, left, acc;
	logic [2:0] err_code;
	int cfg_tpdu = 5;
	int cfg_hdr = 6;

	function automatic bit idle_now();
		if (cyc > 300 && cyc < 700) begin
			return 1'b0;
		end
		return $urandom_range(0, 99) < 6;
	endfunction

	function automatic logic [7:0] hex_digit(input int d);
		d = d & 15;
		return d < 10 ? 8'(8'h30 + d) : 8'(8'h41 + d - 10);
	endfunction

	function automatic void add_word(input logic [2:0] s, input int f, input logic [7:0] c,
		input logic [2:0] st);
		out_word_t w;
		w.section = s;
		w.field_number = 7'(f);
		w.character = c;
		w.last_of_run = 1'b0;
		w.status = st;
		want_q.push_back(w);
	endfunction

	function automatic void fail_parse(input logic [2:0] c);
		err_code = c;
		ph = P_ERR;
		left = 0;
	endfunction

	// Starts the data part of the current field; returns 0 when it is empty.
	function automatic bit open_data();
		int dc;
		int nb;
		dc = def_tab[cur_fld-1][11:10];
		if (dc == CODE_INVALID) begin
			fail_parse(ST_BAD_DATA);
			return 1'b1;
		end
		nb = (dc == CODE_ASCII) ? acc : (acc + 1) / 2;
		if (nb == 0) begin
			return 1'b0;
		end
		ph = P_DATA;
		left = nb;
		return 1'b1;
	endfunction

	// Finds the next present field and sets up its length or data.
	function automatic void next_field();
		int f;
		int kind, lc, fl;
		f = cur_fld + 1;
		if (f < 2) begin
			f = 2;
		end
		for (; f <= 64; f++) begin
			if (!pres_map[64-f]) begin
				continue;
			end
			cur_fld = f;
			kind = def_tab[f-1][15:14];
			lc = def_tab[f-1][13:12];
			if (kind == KIND_INVALID) begin
				fail_parse(ST_BAD_KIND);
				return;
			end
			if (kind == KIND_FIXED) begin
				fl = def_tab[f-1][9:0];
				acc = fl > 999 ? 999 : fl;
				if (open_data()) begin
					return;
				end
				continue;
			end
			if (lc == CODE_INVALID) begin
				fail_parse(ST_BAD_LEN);
				return;
			end
			acc = 0;
			left = (kind == KIND_LL) ? (lc == CODE_ASCII ? 2 : 1) : (lc == CODE_ASCII ? 3 : 2);
			ph = P_LEN;
			return;
		end
		ph = P_DONE;
		left = 0;
	endfunction

	function automatic void enter_section(input int p);
		int n;
		forever begin
			if (p == P_TPDU) n = cfg_tpdu;
			else if (p == P_HDR) n = cfg_hdr;
			else if (p == P_TYPE) n = 2;
			else if (p == P_BMAP) n = 8;
			else begin
				next_field();
				return;
			end
			if (n != 0) begin
				ph = parse_ph_t'(p);
				left = n;
				return;
			end
			p++;
		end
	endfunction

	function automatic void add_len_digit(input int d);
		int v;
		v = acc * 10 + (d > 9 ? 0 : d);
		acc = v > 999 ? 999 : v;
	endfunction

	function automatic void clear_message();
		pres_map = '0;
		ph = P_TPDU;
		cur_fld = 0;
		left = 0;
		acc = 0;
		err_code = ST_OK;
	endfunction

	// Works out the output words caused by one accepted item.
	function automatic void predict_words(input msg_item_t it);
		int start_size;
		int b;
		logic [2:0] st;
		start_size = want_q.size();
		b = it.b;
		if (it.op == OP_LOAD) begin
			def_tab[it.idx] = {it.kind, it.lcode, it.dcode, it.flen};
			return;
		end
		if (ph == P_TPDU && left == 0) begin
			enter_section(P_TPDU);
		end
		case (ph)
			P_TPDU, P_HDR, P_TYPE: begin
				add_word(3'(int'(ph)), 0, hex_digit(b >> 4), ST_OK);
				add_word(3'(int'(ph)), 0, hex_digit(b), ST_OK);
				left--;
				if (left == 0) begin
					enter_section(int'(ph) + 1);
				end
			end
			P_BMAP: begin
				pres_map[63-8*(8-left) -: 8] = it.b;
				left--;
				if (left == 0) begin
					next_field();
				end
			end
			P_LEN: begin
				if (def_tab[cur_fld-1][13:12] == CODE_ASCII) begin
					add_len_digit((b >= 8'h30 && b <= 8'h39) ? b - 8'h30 : 0);
				end else begin
					add_len_digit(b >> 4);
					add_len_digit(b & 15);
				end
				left--;
				if (left == 0 && !open_data()) begin
					next_field();
				end
			end
			P_DATA: begin
				if (def_tab[cur_fld-1][11:10] == CODE_ASCII) begin
					add_word(SEC_FIELD, cur_fld, it.b, ST_OK);
				end else begin
					add_word(SEC_FIELD, cur_fld, hex_digit(b >> 4), ST_OK);
					add_word(SEC_FIELD, cur_fld, hex_digit(b), ST_OK);
				end
				left--;
				if (left == 0) begin
					next_field();
				end
			end
			default: ;
		endcase
		if (it.eom) begin
			if (ph == P_ERR) st = err_code;
			else if (ph == P_DONE) st = ST_OK;
			else st = ST_TRUNC;
			add_word(SEC_STATUS, 0, 8'd0, st);
			clear_message();
		end
		if (want_q.size() > start_size) begin
			want_q[want_q.size()-1].last_of_run = 1'b1;
		end
	endfunction

	// Input driver: presents queued words and predicts each accepted one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			cyc <= cyc + 1;
			if (!in_valid || !in_stall) begin
				if (in_valid) begin
					predict_words(cur_item);
					void'(pending_q.pop_front());
				end
				if (pending_q.size() > 0 && !idle_now()) begin
					cur_item = pending_q[0];
					in_valid <= 1'b1;
					opcode <= cur_item.op;
					def_index <= cur_item.idx;
					len_kind <= cur_item.kind;
					len_coding <= cur_item.lcode;
					data_coding <= cur_item.dcode;
					fixed_length <= cur_item.flen;
					data_byte <= cur_item.b;
					end_of_message <= cur_item.eom;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: random stalls and field-by-field comparison.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= idle_now();
			if (out_valid && !out_stall) begin
				if (want_q.size() == 0) begin
					$error("unexpected word: section %0d character %0h", section, character);
					fails++;
				end else begin
					out_word_t w;
					w = want_q.pop_front();
					if (section !== w.section) begin
						$error("section expected %0d actual %0d", w.section, section);
						fails++;
					end
					if (field_number !== w.field_number) begin
						$error("field_number expected %0d actual %0d", w.field_number,
							field_number);
						fails++;
					end
					if (character !== w.character) begin
						$error("character expected %0h actual %0h", w.character, character);
						fails++;
					end
					if (last_of_run !== w.last_of_run) begin
						$error("last_of_run expected %0d actual %0d", w.last_of_run,
							last_of_run);
						fails++;
					end
					if (status !== w.status) begin
						$error("status expected %0d actual %0d", w.status, status);
						fails++;
					end
				end
			end
		end
	end

	// Watchdog on cycles without any accepted word.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
			|| !arst_n) begin
			quiet_cnt <= 0;
		end else if (quiet_cnt >= 5000) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cnt <= quiet_cnt + 1;
		end
	end

	function automatic msg_item_t rand_item();
		msg_item_t it;
		it.op = OP_BYTE;
		it.idx = 6'($urandom);
		it.kind = 2'($urandom);
		it.lcode = 2'($urandom);
		it.dcode = 2'($urandom);
		it.flen = 10'($urandom);
		it.b = 8'($urandom);
		it.eom = 1'b0;
		return it;
	endfunction

	function automatic int pick_code();
		int r;
		r = $urandom_range(0, 99);
		return r < 50 ? 0 : r < 75 ? 1 : r < 96 ? 2 : 3;
	endfunction

	// Queues a load of one random definition.
	function automatic void load_def(input int idx);
		msg_item_t it;
		int r;
		it = rand_item();
		it.op = OP_LOAD;
		it.idx = 6'(idx);
		r = $urandom_range(0, 99);
		it.kind = r < 40 ? KIND_FIXED : r < 75 ? KIND_LL : r < 96 ? KIND_LLL : KIND_INVALID;
		it.lcode = 2'(pick_code());
		it.dcode = 2'(pick_code());
		r = $urandom_range(0, 199);
		if (r == 0) it.flen = 10'($urandom_range(990, 1023));
		else if (r < 4) it.flen = 10'($urandom_range(512, 1023));
		else it.flen = 10'($urandom_range(0, 10));
		it.eom = 1'($urandom);
		gen_tab[idx] = {it.kind, it.lcode, it.dcode, it.flen};
		pending_q.push_back(it);
	endfunction

	function automatic int pick_len(input int maxv);
		int r;
		r = $urandom_range(0, 99);
		if (r == 0) return maxv;
		return $urandom_range(0, 12);
	endfunction

	// Queues one message; shape 0 well formed, 1 truncated, 2 trailing bytes,
	// 3 random noise. Returns the number of bytes queued.
	function automatic int put_message(input logic [63:0] bmap, input int shape);
		logic [7:0] q[$];
		msg_item_t it;
		int kind, lc, dc, len, nb, cut;
		bit broken;
		broken = 1'b0;
		if (shape == 3) begin
			repeat ($urandom_range(1, 30)) q.push_back(8'($urandom));
		end else begin
			repeat (gen_tpdu + gen_hdr + 2) q.push_back(8'($urandom));
			for (int i = 0; i < 8; i++) q.push_back(bmap[63-8*i -: 8]);
			for (int f = 2; f <= 64 && !broken; f++) begin
				if (!bmap[64-f]) continue;
				kind = gen_tab[f-1][15:14];
				lc = gen_tab[f-1][13:12];
				dc = gen_tab[f-1][11:10];
				if (kind == KIND_INVALID || (kind != KIND_FIXED && lc == CODE_INVALID)) begin
					broken = 1'b1;
					break;
				end
				if (kind == KIND_FIXED) begin
					len = gen_tab[f-1][9:0];
					if (len > 999) len = 999;
				end else begin
					len = pick_len(kind == KIND_LL ? 99 : 999);
					if (lc == CODE_ASCII) begin
						if (kind == KIND_LLL) q.push_back(8'(8'h30 + len / 100));
						q.push_back(8'($urandom_range(0, 39) == 0 ? $urandom : 8'h30 + (len / 10) % 10));
						q.push_back(8'(8'h30 + len % 10));
					end else begin
						if (kind == KIND_LLL) q.push_back(8'(len / 100));
						q.push_back(8'({4'((len / 10) % 10), 4'(len % 10)}
							| ($urandom_range(0, 39) == 0 ? 8'hA0 : 8'h00)));
					end
				end
				if (dc == CODE_INVALID) begin
					broken = 1'b1;
					break;
				end
				nb = dc == CODE_ASCII ? len : (len + 1) / 2;
				repeat (nb) q.push_back(8'($urandom));
			end
			if (broken) repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
			if (shape == 1 && q.size() > 1) begin
				cut = $urandom_range(1, q.size() - 1);
				while (q.size() > cut) void'(q.pop_back());
			end
			if (shape == 2) repeat ($urandom_range(1, 4)) q.push_back(8'($urandom));
		end
		foreach (q[i]) begin
			it = rand_item();
			it.b = q[i];
			it.eom = (i == q.size() - 1);
			pending_q.push_back(it);
		end
		return q.size();
	endfunction

	function automatic logic [63:0] rand_bitmap();
		logic [63:0] m;
		for (int i = 0; i < 64; i++) m[i] = ($urandom_range(0, 15) == 0);
		return m;
	endfunction

	// Waits until every queued word is accepted and every result has come.
	task automatic settle();
		while (pending_q.size() > 0 || in_valid || want_q.size() > 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 4'(val);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_TPDU) cfg_tpdu = val;
		else cfg_hdr = val;
	endtask

	// Stimulus: full table load, directed messages, then random phases.
	initial begin
		int budget;
		int r;
		arst_n = 1'b0;
		opcode = OP_LOAD;
		def_index = '0;
		len_kind = '0;
		len_coding = '0;
		data_coding = '0;
		fixed_length = '0;
		data_byte = '0;
		end_of_message = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TPDU;
		cfg_data = '0;
		clear_message();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < 64; i++) load_def(i);
		void'(put_message(64'd0, 0));
		void'(put_message(64'hE000_0000_0000_0001, 0));
		void'(put_message(64'hFFFF_FFFF_FFFF_FFFF, 1));
		settle();

		for (int phase = 0; phase < 6; phase++) begin
			int tp, hd;
			case (phase)
				0: begin tp = 0; hd = 0; end
				1: begin tp = 15; hd = 15; end
				2: begin tp = 0; hd = 15; end
				3: begin tp = 15; hd = 0; end
				default: begin tp = $urandom_range(0, 15); hd = $urandom_range(0, 15); end
			endcase
			write_reg(CFG_TPDU, tp);
			write_reg(CFG_HEADER, hd);
			gen_tpdu = tp;
			gen_hdr = hd;
			budget = 30;
			while (budget > 0) begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					repeat ($urandom_range(1, 4)) load_def($urandom_range(0, 63));
				end else if (r < 80) begin
					budget -= put_message(rand_bitmap(), 0);
				end else if (r < 88) begin
					budget -= put_message(rand_bitmap(), 1);
				end else if (r < 94) begin
					budget -= put_message(rand_bitmap(), 2);
				end else begin
					budget -= put_message(64'd0, 3);
				end
			end
			settle();
		end

		settle();
		if (fails == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

>>> iso8583_message_unpacker_top.f
rtl/core/ium_pkg.sv
rtl/core/ium_field_table.sv
rtl/core/ium_out_fifo.sv
rtl/core/ium_parser.sv
rtl/core/iso8583_message_unpacker_top.sv
tb/tb_top.sv
